>>> rtl/htok_pkg.sv
// Package for the HTTP request tokenizer: widths, codes, state and word types,
// and the per-byte parse functions used by the parser.
// No dependencies.
package htok_pkg;

    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 12;
    localparam int MLIM_W      = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Register reset values
    localparam logic [MLIM_W-1:0] RST_METHOD_LIMIT = 4'd15;
    localparam logic [CNT_W-1:0]  RST_PATH_LIMIT   = 12'd1023;
    localparam logic [CNT_W-1:0]  RST_QUERY_LIMIT  = 12'd2047;
    localparam logic [CNT_W-1:0]  RST_NAME_LIMIT   = 12'd127;
    localparam logic [CNT_W-1:0]  RST_VALUE_LIMIT  = 12'd2047;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_QM    = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFS = 8'h20;

    typedef enum logic [2:0] {
        MODE_METHOD, MODE_PATH, MODE_QUERY, MODE_VERSION,
        MODE_NAME, MODE_VSKIP, MODE_VALUE, MODE_BODY
    } t_mode;

    typedef enum logic [2:0] {
        KIND_SKIP, KIND_METHOD, KIND_PATH, KIND_QUERY,
        KIND_NAME, KIND_VALUE, KIND_BODY
    } t_kind;

    typedef enum logic [2:0] {
        CLOSE_NONE, CLOSE_METHOD_OK, CLOSE_METHOD_REJ, CLOSE_PATH,
        CLOSE_QUERY, CLOSE_HDR_DONE, CLOSE_HDR_DISC
    } t_close;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_METHOD_LIMIT, CFG_PATH_LIMIT, CFG_QUERY_LIMIT,
        CFG_NAME_LIMIT, CFG_VALUE_LIMIT
    } t_cfg_idx;

    typedef struct packed {
        t_mode            mode;
        logic [CNT_W-1:0] count;
        logic             held_cr;
        logic             line_empty;
    } t_pstate;

    typedef struct packed {
        logic [MLIM_W-1:0] method;
        logic [CNT_W-1:0]  path;
        logic [CNT_W-1:0]  query;
        logic [CNT_W-1:0]  name;
        logic [CNT_W-1:0]  value;
    } t_limits;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
        logic              starts_field;
        t_close            closes;
        logic              run_last;
        logic              request_end;
    } t_tok;

    typedef struct packed {
        t_pstate st;
        t_tok    tok;
    } t_step;

    // Up to two result words from one input byte, in order
    typedef struct packed {
        logic [1:0] n;
        t_tok       first;
        t_tok       second;
    } t_push;

    function automatic t_tok mk_tok(t_kind k, logic [BYTE_W-1:0] d, logic s, t_close c);
        t_tok t;
        t.kind         = k;
        t.data         = d;
        t.starts_field = s;
        t.closes       = c;
        t.run_last     = 1'b0;
        t.request_end  = 1'b0;
        return t;
    endfunction

    // Saturating field byte count
    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] method_lim(t_limits l);
        return {{(CNT_W-MLIM_W){1'b0}}, l.method};
    endfunction

    function automatic t_close method_code(t_pstate s, t_limits l);
        return (s.count <= method_lim(l)) ? CLOSE_METHOD_OK : CLOSE_METHOD_REJ;
    endfunction

    // Keep the byte as field data while under the limit, else tag it skipped
    function automatic t_step keep(t_pstate s, t_kind k, logic [CNT_W-1:0] lim,
                                   logic [BYTE_W-1:0] d);
        t_step r;
        r.st = s;
        if (s.count < lim) begin
            r.tok = mk_tok(k, d, s.count == '0, CLOSE_NONE);
        end else begin
            r.tok = mk_tok(KIND_SKIP, d, 1'b0, CLOSE_NONE);
        end
        r.st.count = bump(s.count);
        return r;
    endfunction

    // Close code for the field still open at end of request
    function automatic t_close open_close(t_pstate s, t_limits l);
        t_close c;
        case (s.mode)
            MODE_METHOD: c = method_code(s, l);
            MODE_PATH:   c = CLOSE_PATH;
            MODE_QUERY:  c = CLOSE_QUERY;
            MODE_NAME:   c = s.line_empty ? CLOSE_NONE : CLOSE_HDR_DISC;
            MODE_VSKIP:  c = CLOSE_HDR_DONE;
            MODE_VALUE:  c = CLOSE_HDR_DONE;
            default:     c = CLOSE_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] to_lower(logic [BYTE_W-1:0] b);
        return (b inside {[CH_UA:CH_UZ]}) ? b + CASE_OFS : b;
    endfunction

    // One ordinary byte through the parse state
    function automatic t_step do_byte(t_pstate s, t_limits l, logic [BYTE_W-1:0] b);
        t_step   r;
        t_pstate t;
        r.st  = s;
        r.tok = mk_tok(KIND_SKIP, b, 1'b0, CLOSE_NONE);
        t     = s;
        case (s.mode)
            MODE_METHOD: begin
                if (b == CH_SP) begin
                    r.tok      = mk_tok(KIND_SKIP, b, 1'b0, method_code(s, l));
                    r.st.mode  = MODE_PATH;
                    r.st.count = '0;
                end else begin
                    r = keep(s, KIND_METHOD, method_lim(l), b);
                end
            end
            MODE_PATH: begin
                if (b inside {CH_SP, CH_QM}) begin
                    r.tok      = mk_tok(KIND_SKIP, b, 1'b0, CLOSE_PATH);
                    r.st.mode  = (b == CH_QM) ? MODE_QUERY : MODE_VERSION;
                    r.st.count = '0;
                end else begin
                    r = keep(s, KIND_PATH, l.path, b);
                end
            end
            MODE_QUERY: begin
                if (b == CH_SP) begin
                    r.tok      = mk_tok(KIND_SKIP, b, 1'b0, CLOSE_QUERY);
                    r.st.mode  = MODE_VERSION;
                    r.st.count = '0;
                end else begin
                    r = keep(s, KIND_QUERY, l.query, b);
                end
            end
            MODE_NAME: begin
                t.line_empty = 1'b0;
                if (b == CH_COLON) begin
                    r.st       = t;
                    r.st.mode  = MODE_VSKIP;
                    r.st.count = '0;
                end else begin
                    r = keep(t, KIND_NAME, l.name, to_lower(b));
                end
            end
            MODE_VSKIP: begin
                if (!(b inside {CH_SP, CH_TAB})) begin
                    t.mode  = MODE_VALUE;
                    t.count = '0;
                    r = keep(t, KIND_VALUE, l.value, b);
                end
            end
            MODE_VALUE: begin
                r = keep(s, KIND_VALUE, l.value, b);
            end
            MODE_BODY: begin
                r.tok      = mk_tok(KIND_BODY, b, s.count == '0, CLOSE_NONE);
                r.st.count = bump(s.count);
            end
            default: begin
                // version part of the request line: skipped
            end
        endcase
        return r;
    endfunction

    // CR LF: blank line starts the body, in the body LF is body data, otherwise closes the open field
    function automatic t_step do_crlf(t_pstate s, t_limits l);
        t_step r;
        r.st = s;
        if (s.mode == MODE_NAME && s.line_empty) begin
            r.st.mode       = MODE_BODY;
            r.st.count      = '0;
            r.st.line_empty = 1'b0;
            r.tok           = mk_tok(KIND_SKIP, CH_LF, 1'b0, CLOSE_NONE);
        end else if (s.mode == MODE_BODY) begin
            r.tok      = mk_tok(KIND_BODY, CH_LF, s.count == '0, CLOSE_NONE);
            r.st.count = bump(s.count);
        end else begin
            r.tok           = mk_tok(KIND_SKIP, CH_LF, 1'b0, open_close(s, l));
            r.st.mode       = MODE_NAME;
            r.st.line_empty = 1'b1;
            r.st.count      = '0;
        end
        return r;
    endfunction

endpackage

>>> rtl/htok_in_if.sv
// Input byte channel of the tokenizer: valid/ready handshake with one request byte.
// Depends on htok_pkg.
interface htok_in_if;
    logic                         valid;
    logic                         ready;
    logic [htok_pkg::BYTE_W-1:0]  in_byte;
    logic                         in_last;

    modport source(output valid, in_byte, in_last, input ready);
    modport sink(input valid, in_byte, in_last, output ready);
endinterface

>>> rtl/htok_out_if.sv
// Result channel of the tokenizer: valid/ready handshake with one tagged byte word.
// Depends on htok_pkg.
interface htok_out_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   kind;
    logic [htok_pkg::BYTE_W-1:0]  data;
    logic                         starts_field;
    logic [2:0]                   closes;
    logic                         run_last;
    logic                         request_end;

    modport source(output valid, kind, data, starts_field, closes, run_last,
                   request_end, input ready);
    modport sink(input valid, kind, data, starts_field, closes, run_last,
                 request_end, output ready);
endinterface

>>> rtl/htok_parser.sv
// Tokenizer parse stage: input register, limit registers, parse state, and the
// single-pass logic that turns one byte into up to two result words.
// Depends on htok_pkg and htok_in_if.
module htok_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [htok_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [htok_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    htok_in_if.sink                             i_req,
    input  logic                                i_room,
    output htok_pkg::t_push                     o_push
);
    import htok_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    t_pstate           r_st;
    t_pstate           n_st;
    t_limits           r_lim;

    logic    consume;
    t_pstate s0;
    t_pstate s1;
    t_pstate s2;
    t_step   sa;
    t_step   sb;
    logic    va;
    logic    vb;
    logic    take;
    logic    hold;
    t_tok    fin;

    localparam t_pstate ST_RESET = '{mode: MODE_METHOD, count: '0,
                                     held_cr: 1'b0, line_empty: 1'b0};

    assign consume     = r_in_valid && i_room;
    assign i_req.ready = !r_in_valid || consume;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_byte <= i_req.in_byte;
            r_in_last <= i_req.in_last;
        end
    end

    // Limit registers; unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim.method <= RST_METHOD_LIMIT;
            r_lim.path   <= RST_PATH_LIMIT;
            r_lim.query  <= RST_QUERY_LIMIT;
            r_lim.name   <= RST_NAME_LIMIT;
            r_lim.value  <= RST_VALUE_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_METHOD_LIMIT: r_lim.method <= i_cfg_data[MLIM_W-1:0];
                CFG_PATH_LIMIT:   r_lim.path   <= i_cfg_data[CNT_W-1:0];
                CFG_QUERY_LIMIT:  r_lim.query  <= i_cfg_data[CNT_W-1:0];
                CFG_NAME_LIMIT:   r_lim.name   <= i_cfg_data[CNT_W-1:0];
                CFG_VALUE_LIMIT:  r_lim.value  <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Held CR first, then the new byte
    always_comb begin
        s0         = r_st;
        s0.held_cr = 1'b0;
        sa         = '{st: s0, tok: mk_tok(KIND_SKIP, CH_CR, 1'b0, CLOSE_NONE)};
        va         = 1'b0;
        take       = 1'b1;
        if (r_st.held_cr) begin
            va = 1'b1;
            if (r_in_byte == CH_LF) begin
                sa   = do_crlf(s0, r_lim);
                take = 1'b0;
            end else begin
                sa = do_byte(s0, r_lim, CH_CR);
            end
        end
        s1   = sa.st;
        hold = take && (r_in_byte == CH_CR) && (s1.mode != MODE_BODY) && !r_in_last;
        vb   = take && !hold;
        sb   = do_byte(s1, r_lim, r_in_byte);
        if (vb) begin
            s2 = sb.st;
        end else begin
            s2         = s1;
            s2.held_cr = hold;
        end
    end

    // Final word of this byte carries run_last and the end-of-request close
    always_comb begin
        fin          = vb ? sb.tok : sa.tok;
        fin.run_last = 1'b1;
        if (r_in_last) begin
            if (fin.closes == CLOSE_NONE) begin
                fin.closes = open_close(s2, r_lim);
            end
            fin.request_end = 1'b1;
        end
        o_push.first  = (va && vb) ? sa.tok : fin;
        o_push.second = fin;
        o_push.n      = consume ? ({1'b0, va} + {1'b0, vb}) : 2'd0;
    end

    assign n_st = r_in_last ? ST_RESET : s2;

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_RESET;
        end else if (consume) begin
            r_st <= n_st;
        end
    end

    a_cr_not_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.held_cr |-> r_st.mode != MODE_BODY)
        else $error("CR held while in body");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && r_in_last |=> r_st.mode == MODE_METHOD && r_st.count == '0
            && !r_st.held_cr && !r_st.line_empty)
        else $error("parse state not cleared after last byte");

    a_cr_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && r_st.held_cr |-> o_push.n != 2'd0)
        else $error("held CR produced no word");

endmodule

>>> rtl/htok_outq.sv
// Result queue of the tokenizer: takes up to two words a cycle, sends one while the output is ready.
// Depends on htok_pkg and htok_out_if.
module htok_outq #(
    parameter int DEPTH = htok_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  htok_pkg::t_push i_push,
    output logic            o_room,
    htok_out_if.source      o_tok
);
    import htok_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_tok          r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_cnt;
    logic          pop;
    logic [AW-1:0] wptr1;
    logic [AW-1:0] wptr2;
    t_tok          head;

    function automatic logic [AW-1:0] inc(logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wptr1  = inc(r_wptr);
    assign wptr2  = inc(wptr1);
    assign pop    = o_tok.valid && o_tok.ready;
    assign o_room = r_cnt <= CW'(DEPTH - 2);

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wptr] <= i_push.first;
        end
        if (i_push.n == 2'd2) begin
            r_mem[wptr1] <= i_push.second;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            case (i_push.n)
                2'd1:    r_wptr <= wptr1;
                2'd2:    r_wptr <= wptr2;
                default: r_wptr <= r_wptr;
            endcase
            if (pop) begin
                r_rptr <= inc(r_rptr);
            end
            r_cnt <= r_cnt + CW'(i_push.n) - CW'(pop);
        end
    end

    // Head word to the port
    assign head               = r_mem[r_rptr];
    assign o_tok.valid        = r_cnt != '0;
    assign o_tok.kind         = head.kind;
    assign o_tok.data         = head.data;
    assign o_tok.starts_field = head.starts_field;
    assign o_tok.closes       = head.closes;
    assign o_tok.run_last     = head.run_last;
    assign o_tok.request_end  = head.request_end;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.n != 2'd0 |-> (int'(r_cnt) + int'(i_push.n)) <= DEPTH)
        else $error("result queue overflow");

endmodule

>>> rtl/http_request_tokenizer_unit.sv
// HTTP request tokenizer top level: parse stage feeding the result queue.
// A byte is accepted into the parse stage's input register, then parsed and written
// to the result queue once the queue has room; its first result word is then valid.
// Throughput: one byte per cycle, input stalling only on output stalls. A held CR
// gives none; a byte after it other than LF or CR gives two, absorbed by the queue.
// Reset (synchronous, active low): parse state cleared, queue emptied, limits
// return to 15/1023/2047/127/2047.
module http_request_tokenizer_unit #(
    parameter int QUEUE_DEPTH = htok_pkg::QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [htok_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [htok_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    htok_in_if.sink                             i_req,
    htok_out_if.source                          o_tok
);
    import htok_pkg::*;

    t_push push;
    logic  room;

    // Byte parser
    htok_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .i_room     (room),
        .o_push     (push)
    );

    // Result word queue
    htok_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_tok   (o_tok)
    );

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok.valid && o_tok.request_end |-> o_tok.run_last)
        else $error("request end on a word that is not the last of its byte");

endmodule
